### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when pre holds, post must hold on the same edge.
`define SVGC_ASSERT_IMPL(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication: when pre holds, post must hold on the following edge.
`define SVGC_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/svgc_pkg.sv
// ----------------------------------------------------------------------------
// svgc_pkg
// Types and constants for the vertical-gradient Sobel filter with clamping.
// ----------------------------------------------------------------------------
package svgc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int PIX_BITS   = 16;
    localparam int ROW_BITS   = 16;
    localparam int CFG_BITS   = 16;
    localparam int WIDTH_BITS = 11;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_VALUE    = 2'd2;

    // Input word action codes
    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    localparam logic [PIX_BITS-1:0] MAX_VALUE_RESET = 16'd255;

    typedef struct packed {
        logic                action;
        logic [PIX_BITS-1:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] edge_value;
        logic [COL_BITS-1:0] out_column;
        logic [ROW_BITS-1:0] out_row;
        logic                frame_last;
    } out_item_t;

endpackage

### rtl/sobel_vertical_gradient_clamp.sv
// ----------------------------------------------------------------------------
// sobel_vertical_gradient_clamp
// Streaming 3x3 Sobel horizontal-edge filter with clamping to 0..max_value.
// ----------------------------------------------------------------------------
// Usage
//   Input channel s_*: one word per pixel in raster order (action = pixel),
//   then image_width+1 flush words (action = flush) to drain the frame.
//   Result channel m_*: one word per output pixel, carrying the clamped
//   response, its column and row, and frame_last on the final pixel.
//   Each result belongs to the pixel width+1 input words earlier.
// Throughput
//   One input word per cycle while the receiver does not stall. An accepted
//   word passes through the input stage and, if it produces a result, on
//   into the result register behind m_valid. The rate is set by the line
//   store: one read at acceptance and one write as the word leaves the input
//   stage, with a bypass when both touch the same column.
// Reset and stall
//   Reset clears the position counters, windows and the line-store fill
//   count, and loads width 640, height 480, max_value 255. The line store
//   needs no clearing pass: columns not yet written read as zero.
//   When the receiver stalls, the result register holds its word, the input
//   stage holds behind it and s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module sobel_vertical_gradient_clamp
    import svgc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int ROWC_BITS = ROW_BITS + 1;
    localparam logic [ROWC_BITS-1:0] ROW_LIMIT = '1;
    localparam int LINE_BITS = 2 * PIX_BITS;
    localparam int FILL_BITS = COL_BITS + 1;
    localparam int SUM_BITS  = PIX_BITS + 2;

    // Input stage contents: the pixel plus every decision made at acceptance
    typedef struct packed {
        logic [PIX_BITS-1:0] pix;
        logic [COL_BITS-1:0] addr;
        logic                col_zero;
        logic                emit;
        logic                mask_left;
        logic                mask_top;
        logic                mask_bottom;
        logic [COL_BITS-1:0] out_col;
        logic [ROW_BITS-1:0] out_row;
        logic                last;
    } stage_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_BITS-1:0] image_width_reg;
    logic [ROW_BITS-1:0]   image_height_reg;
    logic [PIX_BITS-1:0]   max_value_reg;
    logic                  restart;

    assign restart = cfg_wr_en &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_BITS'(640);
            image_height_reg <= ROW_BITS'(480);
            max_value_reg    <= MAX_VALUE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[ROW_BITS-1:0];
                REG_MAX_VALUE:    max_value_reg    <= cfg_data[PIX_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size: width limited to 1..MAX_WIDTH, height at least one
    logic [WIDTH_BITS-1:0] w_eff;
    logic [ROW_BITS-1:0]   h_eff;

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (image_width_reg > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end
        h_eff = (image_height_reg == '0) ? ROW_BITS'(1) : image_height_reg;
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic   s1_valid_reg;
    logic   s1_valid_next;
    stage_t s1_reg;
    logic   s1_adv;
    logic   s_accept;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_load;

    // The input stage moves on whenever the result register is free or being emptied
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;
    assign out_load = s1_adv && s1_reg.emit;

    // ------------------------------------------------------------------
    // Position counters, advanced at acceptance
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0]  in_col_reg,  in_col_next;
    logic [ROWC_BITS-1:0] in_row_reg,  in_row_next;
    logic [COL_BITS-1:0]  out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]  out_row_reg, out_row_next;

    logic [WIDTH_BITS-1:0] in_col_inc;
    logic [WIDTH_BITS-1:0] out_col_inc;
    logic [ROWC_BITS-1:0]  out_row_inc;
    logic                  emit;
    logic                  out_col_wrap;
    logic                  last_row;
    logic                  frame_last;
    logic [PIX_BITS-1:0]   s_pix;

    assign in_col_inc   = {1'b0, in_col_reg} + WIDTH_BITS'(1);
    assign out_col_inc  = {1'b0, out_col_reg} + WIDTH_BITS'(1);
    assign out_row_inc  = {1'b0, out_row_reg} + ROWC_BITS'(1);
    assign emit         = (in_row_reg >= ROWC_BITS'(2)) ||
                          (in_row_reg == ROWC_BITS'(1) && in_col_reg != '0);
    assign out_col_wrap = out_col_inc >= w_eff;
    assign last_row     = out_row_inc >= {1'b0, h_eff};
    assign frame_last   = last_row && out_col_wrap;
    // Flush words enter as zero pixels
    assign s_pix        = (s_data.action == ACTION_FLUSH) ? '0 : s_data.pixel;

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (s_accept) begin
            if (in_col_inc >= w_eff) begin
                in_col_next = '0;
                if (in_row_reg != ROW_LIMIT) begin
                    in_row_next = in_row_reg + ROWC_BITS'(1);
                end
            end else begin
                in_col_next = in_col_inc[COL_BITS-1:0];
            end
            if (emit) begin
                if (frame_last) begin
                    // Final pixel of the image: the next word opens a new frame
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_wrap) begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[ROW_BITS-1:0];
                end else begin
                    out_col_next = out_col_inc[COL_BITS-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: one entry per column, {two rows back, one row back}
    // ------------------------------------------------------------------
    logic [LINE_BITS-1:0] line_mem [0:MAX_WIDTH-1];
    logic [LINE_BITS-1:0] mem_q_reg;
    logic [LINE_BITS-1:0] fwd_data_reg;
    logic                 fwd_reg;
    logic                 rd_ok_reg;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [LINE_BITS-1:0] line_rd;
    logic [LINE_BITS-1:0] wr_data;
    logic [PIX_BITS-1:0]  above;

    // Columns at or beyond the fill count were never written and read as zero
    always_comb begin
        if (fwd_reg) begin
            line_rd = fwd_data_reg;
        end else if (rd_ok_reg) begin
            line_rd = mem_q_reg;
        end else begin
            line_rd = '0;
        end
    end

    assign above   = line_rd[LINE_BITS-1:PIX_BITS];
    assign wr_data = {line_rd[PIX_BITS-1:0], s1_reg.pix};

    // Columns are always visited from zero upward, so written entries form a prefix
    assign fill_next = (s1_adv && {1'b0, s1_reg.addr} == fill_reg) ?
                       fill_reg + FILL_BITS'(1) : fill_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            line_mem[s1_reg.addr] <= wr_data;
        end
        if (s_accept) begin
            mem_q_reg    <= line_mem[in_col_reg];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg   <= 1'b0;
            rd_ok_reg <= 1'b0;
            fill_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            if (s_accept) begin
                // Bypass the write leaving the stage in this same cycle
                fwd_reg   <= s1_adv && (s1_reg.addr == in_col_reg);
                rd_ok_reg <= {1'b0, in_col_reg} < fill_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage register
    // ------------------------------------------------------------------
    assign s1_valid_next = s_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg.pix         <= s_pix;
            s1_reg.addr        <= in_col_reg;
            s1_reg.col_zero    <= (in_col_reg == '0);
            s1_reg.emit        <= emit;
            s1_reg.mask_left   <= (out_col_reg == '0);
            s1_reg.mask_top    <= (out_row_reg == '0);
            s1_reg.mask_bottom <= last_row;
            s1_reg.out_col     <= out_col_reg;
            s1_reg.out_row     <= out_row_reg;
            s1_reg.last        <= frame_last;
        end
    end

    // ------------------------------------------------------------------
    // Windows: the two newest taps of the upper and lower rows
    // ------------------------------------------------------------------
    logic [PIX_BITS-1:0] top1_reg, top2_reg;
    logic [PIX_BITS-1:0] bot1_reg, bot2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            top1_reg      <= '0;
            top2_reg      <= '0;
            bot1_reg      <= '0;
            bot2_reg      <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            if (s1_adv) begin
                top1_reg <= top2_reg;
                top2_reg <= above;
                bot1_reg <= bot2_reg;
                bot2_reg <= s1_reg.pix;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response: upper row weighted 1,2,1, lower row -1,-2,-1
    // ------------------------------------------------------------------
    logic [PIX_BITS-1:0] tl, tc, tr, bl, bc, br;
    logic [SUM_BITS-1:0] top_sum, bot_sum, diff;
    logic [PIX_BITS-1:0] edge_val;

    always_comb begin
        // On a first-column word the output sits at the row end: right taps drop
        tl = (s1_reg.mask_left || s1_reg.mask_top) ? '0 : top1_reg;
        tc = s1_reg.mask_top ? '0 : top2_reg;
        tr = (s1_reg.col_zero || s1_reg.mask_top) ? '0 : above;
        bl = (s1_reg.mask_left || s1_reg.mask_bottom) ? '0 : bot1_reg;
        bc = s1_reg.mask_bottom ? '0 : bot2_reg;
        br = (s1_reg.col_zero || s1_reg.mask_bottom) ? '0 : s1_reg.pix;

        top_sum = SUM_BITS'(tl) + {1'b0, tc, 1'b0} + SUM_BITS'(tr);
        bot_sum = SUM_BITS'(bl) + {1'b0, bc, 1'b0} + SUM_BITS'(br);
        diff    = top_sum - bot_sum;

        // Clamp: negative to zero, above max_value to max_value
        if (bot_sum >= top_sum) begin
            edge_val = '0;
        end else if (diff > SUM_BITS'(max_value_reg)) begin
            edge_val = max_value_reg;
        end else begin
            edge_val = diff[PIX_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    out_item_t out_reg;

    assign out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.edge_value <= edge_val;
            out_reg.out_column <= s1_reg.out_col;
            out_reg.out_row    <= s1_reg.out_row;
            out_reg.frame_last <= s1_reg.last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/svgc_checker.sv
// ----------------------------------------------------------------------------
// svgc_checker
// Port-level checks on the Sobel filter: stalls, clamping, output raster order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svgc_checker
    import svgc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input out_item_t           m_data,
    input logic                cfg_wr_en,
    input logic [1:0]          cfg_index,
    input logic [CFG_BITS-1:0] cfg_data
);

    logic                m_take;
    logic                fresh_reg;
    logic [COL_BITS-1:0] prev_col_reg;
    logic [ROW_BITS-1:0] prev_row_reg;
    logic [PIX_BITS-1:0] max_reg;

    assign m_take = m_valid && m_ready;

    // Track the last delivered position and the clamp limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg    <= 1'b1;
            prev_col_reg <= '0;
            prev_row_reg <= '0;
            max_reg      <= MAX_VALUE_RESET;
        end else begin
            if (cfg_wr_en &&
                (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
                fresh_reg <= 1'b1;
            end else if (m_take) begin
                fresh_reg <= m_data.frame_last;
            end
            if (m_take) begin
                prev_col_reg <= m_data.out_column;
                prev_row_reg <= m_data.out_row;
            end
            if (cfg_wr_en && cfg_index == REG_MAX_VALUE) begin
                max_reg <= cfg_data[PIX_BITS-1:0];
            end
        end
    end

    `SVGC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result word changed while stalled")

    `SVGC_ASSERT_IMPL(a_ready_only_on_stall, aclk, aresetn, !s_ready,
        m_valid && !m_ready, "input refused without a stalled result")

    `SVGC_ASSERT_IMPL(a_clamped, aclk, aresetn, m_valid,
        m_data.edge_value <= max_reg, "response above max_value")

    `SVGC_ASSERT_IMPL(a_frame_start, aclk, aresetn, m_take && fresh_reg,
        m_data.out_column == '0 && m_data.out_row == '0, "frame does not start at origin")

    `SVGC_ASSERT_IMPL(a_raster_step, aclk, aresetn,
        m_take && !fresh_reg && m_data.out_column != '0,
        m_data.out_column == prev_col_reg + COL_BITS'(1) && m_data.out_row == prev_row_reg,
        "output column skipped or repeated")

endmodule

bind sobel_vertical_gradient_clamp svgc_checker u_svgc_checker (.*);

### verif/sobel_vertical_gradient_clamp_test.sv
// ----------------------------------------------------------------------------
// sobel_vertical_gradient_clamp_test
// Self-checking bench for the streaming vertical-gradient Sobel filter.
// Frames of random size and content go in with random gaps on both channels.
// A bit-true software copy of the filter predicts every edge word, and a
// scoreboard compares each one in order, field by field.
// ----------------------------------------------------------------------------
module sobel_vertical_gradient_clamp_test
    import svgc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1920;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 6;
    localparam int MAX_GAP      = 17;

    typedef enum {
        FRAME_CLEAN,
        FRAME_PIXEL_DRAIN,
        FRAME_NOISY,
        FRAME_TRUNCATED,
        FRAME_EXTRA_FLUSH
    } frame_kind_e;

    // ------------------------------------------------------------------------
    // Scoreboard: carries its own copy of the filter state and registers,
    // predicts the edge word (if any) for each accepted input word and
    // checks the result words against the oldest prediction.
    // ------------------------------------------------------------------------
    class edge_scoreboard;
        out_item_t       pending_edges[$];
        int              errors;
        int              checked;
        logic [15:0]     older_line[MAX_WIDTH];
        logic [15:0]     newer_line[MAX_WIDTH];
        logic [15:0]     top_taps[3];
        logic [15:0]     bottom_taps[3];
        int unsigned     in_col, in_row, out_col, out_row;
        logic [10:0]     width_reg;
        logic [15:0]     height_reg, max_reg;

        function new();
            errors = 0;
            checked = 0;
            width_reg = 11'd640;
            height_reg = 16'd480;
            max_reg = MAX_VALUE_RESET;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            for (int i = 0; i < 3; i++) begin
                top_taps[i] = '0;
                bottom_taps[i] = '0;
            end
            restart();
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void apply_register(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_IMAGE_WIDTH: begin
                    width_reg = val[10:0];
                    restart();
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg = val;
                    restart();
                end
                REG_MAX_VALUE: begin
                    max_reg = val;
                end
                default: ;
            endcase
        endfunction

        // Advance the filter by one input word and queue the edge word it yields, if any.
        function void note_pixel_word(in_item_t word);
            int unsigned wd, ht, pix, col, row;
            bit          emit, last;
            logic [15:0] pt1, pt2, pb1, pb2, above;
            int          tl, tc, tr, bl, bc, br, sum;
            logic [15:0] grad;
            out_item_t   res;

            wd = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
            ht = (height_reg < 1) ? 1 : height_reg;
            pix = (word.action == ACTION_FLUSH) ? 0 : word.pixel;
            col = in_col;
            row = in_row;
            emit = (row >= 2) || (row == 1 && col >= 1);
            pt1 = top_taps[1];
            pt2 = top_taps[2];
            pb1 = bottom_taps[1];
            pb2 = bottom_taps[2];
            above = '0;

            if (col < MAX_WIDTH) begin
                above = older_line[col];
                older_line[col] = newer_line[col];
                newer_line[col] = pix[15:0];
            end
            top_taps[0] = top_taps[1];
            top_taps[1] = top_taps[2];
            top_taps[2] = above;
            bottom_taps[0] = bottom_taps[1];
            bottom_taps[1] = bottom_taps[2];
            bottom_taps[2] = pix[15:0];

            in_col = col + 1;
            if (in_col >= wd) begin
                in_col = 0;
                if (in_row < 32'h1FFFF) in_row++;
            end

            if (!emit) return;

            if (col == 0) begin
                // output on the last column: right neighbour lies outside
                tl = pt1; tc = pt2; tr = 0;
                bl = pb1; bc = pb2; br = 0;
            end else begin
                tl = top_taps[0]; tc = top_taps[1]; tr = top_taps[2];
                bl = bottom_taps[0]; bc = bottom_taps[1]; br = bottom_taps[2];
            end
            if (out_col == 0) begin
                tl = 0;
                bl = 0;
            end
            if (out_row == 0) begin
                tl = 0; tc = 0; tr = 0;
            end
            if (out_row + 1 >= ht) begin
                bl = 0; bc = 0; br = 0;
            end

            sum = tl + 2 * tc + tr - bl - 2 * bc - br;
            if (sum < 0) grad = '0;
            else if (sum > int'(max_reg)) grad = max_reg;
            else grad = sum[15:0];

            last = (out_row + 1 >= ht) && (out_col + 1 >= wd);

            res.edge_value = grad;
            res.out_column = out_col[COL_BITS-1:0];
            res.out_row    = out_row[ROW_BITS-1:0];
            res.frame_last = last;
            pending_edges.push_back(res);

            if (last) begin
                restart();
            end else begin
                out_col++;
                if (out_col >= wd) begin
                    out_col = 0;
                    out_row = (out_row + 1) & 32'hFFFF;
                end
            end
        endfunction

        function void check_edge_word(out_item_t got);
            out_item_t want;
            if (pending_edges.size() == 0) begin
                $error("unexpected edge word: edge_value %0d, column %0d, row %0d",
                       got.edge_value, got.out_column, got.out_row);
                errors++;
                return;
            end
            want = pending_edges.pop_front();
            checked++;
            if (got.edge_value !== want.edge_value) begin
                $error("edge_value: expected %0d, got %0d", want.edge_value, got.edge_value);
                errors++;
            end
            if (got.out_column !== want.out_column) begin
                $error("out_column: expected %0d, got %0d", want.out_column, got.out_column);
                errors++;
            end
            if (got.out_row !== want.out_row) begin
                $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                errors++;
            end
            if (got.frame_last !== want.frame_last) begin
                $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    edge_scoreboard sb;
    int             cycles = 0;
    int             words_sent;
    int             frames_run;
    int             cur_w, cur_h;
    bit             send_idle, recv_idle;
    bit             need_restart;

    sobel_vertical_gradient_clamp u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 12 ns period
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Watchdog: give up if the run hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** sobel_vertical_gradient_clamp: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Inputs change on the falling edge only; handshakes are
    // sampled on the rising edge, before the block's registers move.
    // ------------------------------------------------------------------------

    // Drop valid on the next falling edge so the input channel goes quiet.
    task automatic hold_input();
        @(negedge aclk) s_valid <= 1'b0;
    endtask

    // Present one word after a random gap and hold it until it is taken.
    task automatic send_word(input in_item_t word);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= word;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel_word(word);
        words_sent++;
    endtask

    // Stop sending and wait until every predicted edge word has come back,
    // then give the input stage time to empty of words that yield nothing.
    task automatic settle_block();
        hold_input();
        while (sb.pending_edges.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    // Register writes only ever happen with the block idle.
    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        settle_block();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.apply_register(idx, val);
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    // Write width and height (which restarts the frame) and note the sizes
    // the block will actually use.
    task automatic configure_frame(input int wreg, input int hreg);
        write_register(REG_IMAGE_WIDTH, 16'(wreg & 'h7FF));
        write_register(REG_IMAGE_HEIGHT, 16'(hreg));
        cur_w = ((wreg & 'h7FF) < 1) ? 1 : (((wreg & 'h7FF) > MAX_WIDTH) ? MAX_WIDTH : (wreg & 'h7FF));
        cur_h = (hreg < 1) ? 1 : hreg;
        need_restart = 1'b0;
    endtask

    // Pixel values lean towards the extremes but cover every bit.
    function automatic logic [15:0] draw_pixel();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] draw_max_value();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3: return 16'd255;
            4: return 16'($urandom_range(0, 1023));
            default: return 16'($urandom());
        endcase
    endfunction

    // Send one frame of the current size in the chosen shape.
    task automatic run_frame(input frame_kind_e kind);
        int       n_pix, n_drain, stop;
        in_item_t word;
        n_pix   = cur_w * cur_h;
        n_drain = cur_w + 1;
        stop    = n_pix + n_drain;
        if (kind == FRAME_TRUNCATED) stop = $urandom_range(1, n_pix + n_drain - 1);
        for (int i = 0; i < stop; i++) begin
            if (i < n_pix) begin
                word.action = (kind == FRAME_NOISY && $urandom_range(0, 5) == 0) ?
                              ACTION_FLUSH : ACTION_PIXEL;
            end else begin
                // drain: flush words, or plain pixels that fall past the frame
                word.action = (kind == FRAME_PIXEL_DRAIN) ? ACTION_PIXEL : ACTION_FLUSH;
            end
            word.pixel = draw_pixel();
            send_word(word);
        end
        if (kind == FRAME_EXTRA_FLUSH) begin
            repeat ($urandom_range(1, 3)) begin
                word.action = ACTION_FLUSH;
                word.pixel  = draw_pixel();
                send_word(word);
            end
        end
        // a broken frame leaves the counters mid-frame: restart before the next
        if (kind == FRAME_TRUNCATED || kind == FRAME_EXTRA_FLUSH) need_restart = 1'b1;
        frames_run++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, every accepted word checked.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_edge_word(m_data);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int          random_start, wreg, hreg, pick;
        frame_kind_e kind;
        in_item_t    word;

        // Known values on every input from time zero
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        words_sent = 0;
        frames_run = 0;
        send_idle  = 1'b1;
        recv_idle  = 1'b1;
        cur_w = 640;
        cur_h = 480;
        need_restart = 1'b0;
        sb = new();

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: a 3x3 frame with full-scale rows and the widest clamp
        write_register(REG_MAX_VALUE, 16'hFFFF);
        configure_frame(3, 3);
        word.action = ACTION_PIXEL;
        word.pixel = 16'hFFFF; send_word(word); send_word(word); send_word(word);
        word.pixel = 16'h0000; send_word(word);
        word.pixel = 16'hFFFF; send_word(word);
        word.pixel = 16'h0000; send_word(word);
        word.pixel = 16'd1;    send_word(word);
        word.pixel = 16'd2;    send_word(word);
        word.pixel = 16'd3;    send_word(word);
        // flush words carry junk that must be ignored
        word.action = ACTION_FLUSH;
        word.pixel  = 16'hFFFF;
        repeat (4) send_word(word);

        // Directed: height zero acts as one row, clamp at one
        write_register(REG_MAX_VALUE, 16'd1);
        configure_frame(2, 0);
        word.action = ACTION_PIXEL;
        word.pixel = 16'hFFFF; send_word(word);
        word.pixel = 16'h0000; send_word(word);
        word.action = ACTION_FLUSH;
        repeat (3) send_word(word);

        // Directed: width zero acts as one column; response saturates at 255
        write_register(REG_MAX_VALUE, 16'd255);
        configure_frame(0, 2);
        word.action = ACTION_PIXEL;
        word.pixel = 16'h00FF; send_word(word);
        word.pixel = 16'h0000; send_word(word);
        word.action = ACTION_FLUSH;
        word.pixel  = 16'h5A5A;
        repeat (2) send_word(word);
        // a stray flush outside a drain opens a new frame as a zero pixel
        send_word(word);
        need_restart = 1'b1;

        // Random frames, mostly well formed, now and then broken
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);

            // hold off now and then until the block has delivered everything
            if ($urandom_range(0, 9) == 0) settle_block();

            if (frames_run == 8) begin
                // width beyond range and the tallest height: a partial frame
                // that reaches into the second row, then a restart
                configure_frame(2047, 65535);
                word.action = ACTION_PIXEL;
                for (int i = 0; i < MAX_WIDTH + 60; i++) begin
                    word.pixel = draw_pixel();
                    send_word(word);
                end
                need_restart = 1'b1;
                frames_run++;
            end else begin
                if ($urandom_range(0, 3) == 0) write_register(REG_MAX_VALUE, draw_max_value());
                if (need_restart || $urandom_range(0, 2) == 0) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0) wreg = 0;
                    else if (pick == 1) wreg = $urandom_range(9, 64);
                    else wreg = $urandom_range(1, 8);
                    pick = $urandom_range(0, 9);
                    if (pick == 0) hreg = 0;
                    else if (pick == 1 && wreg <= 8) hreg = $urandom_range(7, 20);
                    else hreg = $urandom_range(1, 6);
                    configure_frame(wreg, hreg);
                end
                pick = $urandom_range(0, 9);
                if (pick <= 5) kind = FRAME_CLEAN;
                else if (pick == 6) kind = FRAME_PIXEL_DRAIN;
                else if (pick == 7) kind = FRAME_NOISY;
                else if (pick == 8) kind = FRAME_TRUNCATED;
                else kind = FRAME_EXTRA_FLUSH;
                run_frame(kind);
            end
        end

        // Drain: wait for every outstanding edge word, then a little longer
        // to catch anything spurious.
        hold_input();
        while (sb.pending_edges.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.pending_edges.size() != 0) begin
            $error("%0d edge words never arrived", sb.pending_edges.size());
            sb.errors++;
        end

        $display("Run covered %0d input words over %0d frames, %0d edge words checked,",
                 words_sent, frames_run, sb.checked);
        $display("with widths from 1 to %0d and random stalls on both channels.", MAX_WIDTH);
        if (sb.errors == 0) begin
            $display("** sobel_vertical_gradient_clamp: PASSED **");
        end else begin
            $display("** sobel_vertical_gradient_clamp: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/svgc_pkg.sv
rtl/sobel_vertical_gradient_clamp.sv
rtl/svgc_checker.sv
verif/sobel_vertical_gradient_clamp_test.sv
